// ----- design/assert_macros.svh -----
// Assertion helpers used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked property, ignored while reset is asserted.
`define ASSERT_CLK(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
    else $error("assertion failed");

// Clocked implication, ignored while reset is asserted.
`define ASSERT_IMP(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("implication failed");

`endif

// ----- design/bmcsr_pkg.sv -----
`timescale 1ns / 1ps
package bmcsr_pkg;

  localparam int unsigned MaxRows      = 65536;
  localparam int unsigned RowW         = 17;
  localparam int unsigned OffW         = 11;
  localparam int unsigned HwW          = 10;
  localparam int unsigned CntW         = 27;
  localparam int unsigned CfgIdxW      = 8;
  localparam int unsigned OutDataW     = 80;

  localparam logic [31:0]   OneBits  = 32'h3F80_0000;
  localparam logic [CntW-1:0] CountMax = {CntW{1'b1}};

  // Register indexes
  typedef enum logic [CfgIdxW-1:0] {
    REG_NUM_ROWS   = 8'd0,
    REG_HALF_WIDTH = 8'd1,
    REG_THRESHOLD  = 8'd2,
    REG_ONE_BASED  = 8'd3
  } reg_idx_e;

  // Result kinds
  typedef enum logic {
    KIND_ENTRY  = 1'b0,
    KIND_ROWPTR = 1'b1
  } kind_e;

  typedef struct packed {
    logic [RowW-1:0] num_rows;
    logic [HwW-1:0]  half_width;
    logic [31:0]     threshold;
    logic            one_based;
  } cfg_t;

  typedef struct packed {
    logic [RowW-1:0] row;
    logic [OffW-1:0] off;
    logic [CntW-1:0] cnt;
  } state_t;

  typedef struct packed {
    kind_e           kind;
    logic [RowW-1:0] col;
    logic [31:0]     value;
    logic [CntW-1:0] rowptr;
    logic            last;
  } res_t;

endpackage

// ----- design/banded_matrix_to_csr_filter_core.sv -----
`timescale 1ns / 1ps
// An accepted item's results are written into the registered output queue.
// Throughput: one item per cycle while the output keeps up; a row end gives
// up to two results, drained one per cycle from a four-entry output queue.
// Reset: asynchronous active low; clears counters, queue and registers to
// num_rows 1, half_width 0, threshold 0, zero-based columns.
module banded_matrix_to_csr_filter_core (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [31:0] s_axis_tdata,   // [31:0] sample_bits
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [79:0] m_axis_tdata,   // [16:0] column_index, [48:17] value_bits,
                                      // [75:49] row_pointer, [79:76] zero
  output logic        m_axis_tuser,   // [0] kind
  output logic        m_axis_tlast,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [7:0]  cfg_index_i,
  input  logic [31:0] cfg_data_i
);

  bmcsr_pkg::cfg_t   cfg_q;
  bmcsr_pkg::state_t st_q, st_d;
  bmcsr_pkg::res_t   res0, res1, head;
  logic keep, row_end, accept, room;

  assign cfg_ready_o   = 1'b1;
  assign s_axis_tready = room;
  assign accept        = s_axis_tvalid && room;

  // Configuration writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.num_rows   <= bmcsr_pkg::RowW'(1);
      cfg_q.half_width <= '0;
      cfg_q.threshold  <= '0;
      cfg_q.one_based  <= 1'b0;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        bmcsr_pkg::REG_NUM_ROWS:   cfg_q.num_rows   <= cfg_data_i[bmcsr_pkg::RowW-1:0];
        bmcsr_pkg::REG_HALF_WIDTH: cfg_q.half_width <= cfg_data_i[bmcsr_pkg::HwW-1:0];
        bmcsr_pkg::REG_THRESHOLD:  cfg_q.threshold  <= cfg_data_i;
        bmcsr_pkg::REG_ONE_BASED:  cfg_q.one_based  <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  bmcsr_eval u_eval (
    .cfg_i     (cfg_q),
    .st_i      (st_q),
    .sample_i  (s_axis_tdata),
    .st_o      (st_d),
    .keep_o    (keep),
    .row_end_o (row_end),
    .res0_o    (res0),
    .res1_o    (res1)
  );

  // Advance row state on each accepted item
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= '0;
    end else if (accept) begin
      st_q <= st_d;
    end
  end

  bmcsr_outq u_outq (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push0_i (accept && keep),
    .push1_i (accept && row_end),
    .data0_i (res0),
    .data1_i (res1),
    .room_o  (room),
    .valid_o (m_axis_tvalid),
    .pop_i   (m_axis_tready),
    .data_o  (head)
  );

  // Pack the head item
  assign m_axis_tdata = {4'b0000, head.rowptr, head.value, head.col};
  assign m_axis_tuser = head.kind;
  assign m_axis_tlast = head.last;

endmodule

// ----- design/bmcsr_eval.sv -----
`timescale 1ns / 1ps
// Per-item evaluation: filter one band entry and derive the next counters.
module bmcsr_eval (
  input  bmcsr_pkg::cfg_t   cfg_i,
  input  bmcsr_pkg::state_t st_i,
  input  logic [31:0]       sample_i,
  output bmcsr_pkg::state_t st_o,
  output logic              keep_o,
  output logic              row_end_o,
  output bmcsr_pkg::res_t   res0_o,
  output bmcsr_pkg::res_t   res1_o
);

  logic [bmcsr_pkg::RowW-1:0] rows;
  logic [bmcsr_pkg::OffW-1:0] hw_ext;
  logic                       center;
  logic [31:0]                b;
  logic                       finite;
  logic [30:0]                mag;
  logic                       thr_nan;
  logic                       above;
  logic [bmcsr_pkg::RowW:0]   sum;
  logic [bmcsr_pkg::RowW:0]   col_w;
  logic                       in_range;
  logic [bmcsr_pkg::RowW-1:0] col_out;
  logic [bmcsr_pkg::CntW-1:0] cnt_inc;

  // Clamp row count and substitute the centre entry
  always_comb begin
    rows = (cfg_i.num_rows > bmcsr_pkg::RowW'(bmcsr_pkg::MaxRows)) ?
           bmcsr_pkg::RowW'(bmcsr_pkg::MaxRows) : cfg_i.num_rows;
    hw_ext = {1'b0, cfg_i.half_width};
    center = (st_i.off == hw_ext);
    b      = center ? bmcsr_pkg::OneBits : sample_i;
  end

  // Magnitude compare against the threshold as float32
  always_comb begin
    finite  = (b[30:23] != 8'hFF);
    mag     = b[30:0];
    thr_nan = (cfg_i.threshold[30:23] == 8'hFF) && (cfg_i.threshold[22:0] != 23'd0);
    if (thr_nan) begin
      above = 1'b0;
    end else if (cfg_i.threshold[31]) begin
      above = (mag != 31'd0) || (cfg_i.threshold[30:0] != 31'd0);
    end else begin
      above = (mag > cfg_i.threshold[30:0]);
    end
  end

  // Column range check
  always_comb begin
    sum      = {1'b0, st_i.row} + {{(bmcsr_pkg::RowW+1-bmcsr_pkg::OffW){1'b0}}, st_i.off};
    col_w    = sum - {{(bmcsr_pkg::RowW+1-bmcsr_pkg::HwW){1'b0}}, cfg_i.half_width};
    in_range = (sum >= {{(bmcsr_pkg::RowW+1-bmcsr_pkg::HwW){1'b0}}, cfg_i.half_width}) &&
               (col_w < {1'b0, rows});
    keep_o   = finite && above && in_range;
    col_out  = col_w[bmcsr_pkg::RowW-1:0] + {{(bmcsr_pkg::RowW-1){1'b0}}, cfg_i.one_based};
  end

  // Counter update
  always_comb begin
    row_end_o = (st_i.off >= {cfg_i.half_width, 1'b0});
    cnt_inc   = (keep_o && (st_i.cnt != bmcsr_pkg::CountMax)) ?
                st_i.cnt + bmcsr_pkg::CntW'(1) : st_i.cnt;
    st_o.cnt  = cnt_inc;
    st_o.row  = st_i.row;
    st_o.off  = st_i.off + bmcsr_pkg::OffW'(1);
    if (row_end_o) begin
      st_o.off = '0;
      if ({1'b0, st_i.row} + (bmcsr_pkg::RowW+1)'(1) >= {1'b0, rows}) begin
        st_o.row = '0;
        st_o.cnt = '0;
      end else begin
        st_o.row = st_i.row + bmcsr_pkg::RowW'(1);
      end
    end
  end

  // Build the two possible results
  always_comb begin
    res0_o.kind   = bmcsr_pkg::KIND_ENTRY;
    res0_o.col    = col_out;
    res0_o.value  = b;
    res0_o.rowptr = '0;
    res0_o.last   = !row_end_o;
    res1_o.kind   = bmcsr_pkg::KIND_ROWPTR;
    res1_o.col    = '0;
    res1_o.value  = '0;
    res1_o.rowptr = cnt_inc;
    res1_o.last   = 1'b1;
  end

endmodule

// ----- design/bmcsr_outq.sv -----
`timescale 1ns / 1ps
// Four-entry result queue taking up to two items per cycle, giving one.
module bmcsr_outq (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push0_i,
  input  logic            push1_i,
  input  bmcsr_pkg::res_t data0_i,
  input  bmcsr_pkg::res_t data1_i,
  output logic            room_o,
  output logic            valid_o,
  input  logic            pop_i,
  output bmcsr_pkg::res_t data_o
);

  bmcsr_pkg::res_t mem_q [4];
  logic [1:0] wp_q, wp_d, rp_q, rp_d;
  logic [2:0] cnt_q, cnt_d;
  logic       do_pop;
  logic [1:0] wa0, wa1;
  logic [1:0] npush;

  // Pointer and fill arithmetic
  always_comb begin
    do_pop = pop_i && valid_o;
    npush  = {1'b0, push0_i} + {1'b0, push1_i};
    wa0    = wp_q;
    wa1    = push0_i ? wp_q + 2'd1 : wp_q;
    wp_d   = wp_q + npush;
    rp_d   = do_pop ? rp_q + 2'd1 : rp_q;
    cnt_d  = cnt_q + {1'b0, npush} - {2'b00, do_pop};
  end

  assign valid_o = (cnt_q != 3'd0);
  assign room_o  = (cnt_q <= 3'd2);
  assign data_o  = mem_q[rp_q];

  // Advance pointers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= '0;
      rp_q  <= '0;
      cnt_q <= '0;
    end else begin
      wp_q  <= wp_d;
      rp_q  <= rp_d;
      cnt_q <= cnt_d;
    end
  end

  // Store items
  always_ff @(posedge clk_i) begin
    if (push0_i) begin
      mem_q[wa0] <= data0_i;
    end
    if (push1_i) begin
      mem_q[wa1] <= data1_i;
    end
  end

endmodule

// ----- design/bmcsr_checker.sv -----
`timescale 1ns / 1ps
`include "assert_macros.svh"
// Port-level checks on the result stream.
module bmcsr_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [79:0] m_axis_tdata,
  input logic        m_axis_tuser,
  input logic        m_axis_tlast
);

  `ASSERT_IMP(a_ptr_last, clk_i, rst_ni, m_axis_tvalid && m_axis_tuser, m_axis_tlast)
  `ASSERT_IMP(a_ptr_zero, clk_i, rst_ni, m_axis_tvalid && m_axis_tuser, m_axis_tdata[48:0] == 49'd0)
  `ASSERT_IMP(a_ent_zero, clk_i, rst_ni, m_axis_tvalid && !m_axis_tuser, m_axis_tdata[79:49] == 31'd0)
  `ASSERT_CLK(a_hold, clk_i, rst_ni,
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))

endmodule

bind banded_matrix_to_csr_filter_core bmcsr_checker u_bmcsr_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser),
  .m_axis_tlast  (m_axis_tlast)
);
